@@ hdl/ntcb_pkg.sv @@
// Shared types and constants for the NTC thermistor Beta temperature pipeline.
// No dependencies; imported by ntcb_log, the top level and the testbench.
package ntcb_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_RAIL = 2'd1,
        ST_RES  = 2'd2,
        ST_TEMP = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SUPPLY_MV    = 3'd0,
        CFG_FIXED_OHMS   = 3'd1,
        CFG_NOMINAL_OHMS = 3'd2,
        CFG_BETA_KELVIN  = 3'd3,
        CFG_NOMINAL_CK   = 3'd4,
        CFG_RAIL_MARGIN  = 3'd5,
        CFG_TEMP_LOW     = 3'd6,
        CFG_TEMP_HIGH    = 3'd7
    } t_cfg_idx;

    localparam int CFG_DATA_W = 20;
    localparam int LOG_FRAC   = 26;          // fraction bits of log2
    localparam int LOG_W      = 5 + LOG_FRAC; // integer part 0..31
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [40:0] CK_OFFSET = 41'd27315;
    // 100 * 2^32 as the numerator of both reciprocals
    localparam logic [38:0] RECIP_NUM = 39'd429496729600;

    // reset values
    localparam logic [12:0] RST_SUPPLY_MV   = 13'd3300;
    localparam logic [19:0] RST_FIXED_OHMS  = 20'd10000;
    localparam logic [19:0] RST_NOM_OHMS    = 20'd10000;
    localparam logic [13:0] RST_BETA        = 14'd3470;
    localparam logic [15:0] RST_NOM_CK      = 16'd29815;
    localparam logic [8:0]  RST_RAIL_MARGIN = 9'd10;
    localparam logic signed [15:0] RST_TEMP_LOW  = -16'sd1000;
    localparam logic signed [15:0] RST_TEMP_HIGH = 16'sd12000;

endpackage

@@ hdl/ntcb_in_if.sv @@
// Input channel: one divider voltage request per handshake.
// Standalone interface, no package dependency.
interface ntcb_in_if;
    logic        valid;
    logic        ready;
    logic [12:0] sense_mv;

    modport source (output valid, output sense_mv, input ready);
    modport sink   (input valid, input sense_mv, output ready);
endinterface

@@ hdl/ntcb_out_if.sv @@
// Output channel: temperature and status per handshake.
// Standalone interface, no package dependency.
interface ntcb_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_centi_c;
    logic [1:0]         status;

    modport source (output valid, output temperature_centi_c, output status, input ready);
    modport sink   (input valid, input temperature_centi_c, input status, output ready);
endinterface

@@ hdl/ntcb_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a side word alongside the quotient. Uses no package items.
module ntcb_div #(
    parameter int NUM_W  = 39,
    parameter int DEN_W  = 14,
    parameter int SIDE_W = 2
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_rest [NUM_W];
    logic [NUM_W-1:0]  r_quo  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    genvar g;
    generate
        for (g = 0; g < NUM_W; g++) begin : g_stage
            logic [DEN_W-1:0]  p_rem;
            logic [NUM_W-1:0]  p_rest;
            logic [NUM_W-1:0]  p_quo;
            logic [DEN_W-1:0]  p_den;
            logic [SIDE_W-1:0] p_side;
            logic [DEN_W:0]    trial;
            logic              qbit;
            logic [DEN_W-1:0]  n_rem;

            // previous stage or pipeline entry
            if (g == 0) begin : g_first
                assign p_rem  = '0;
                assign p_rest = i_num;
                assign p_quo  = '0;
                assign p_den  = i_den;
                assign p_side = i_side;
            end else begin : g_next
                assign p_rem  = r_rem[g-1];
                assign p_rest = r_rest[g-1];
                assign p_quo  = r_quo[g-1];
                assign p_den  = r_den[g-1];
                assign p_side = r_side[g-1];
            end

            // trial subtract of one bit
            always_comb begin
                trial = {p_rem, p_rest[NUM_W-1]};
                qbit  = (trial >= {1'b0, p_den});
                if (qbit) begin
                    n_rem = DEN_W'(trial - {1'b0, p_den});
                end else begin
                    n_rem = trial[DEN_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g]  <= n_rem;
                    r_rest[g] <= {p_rest[NUM_W-2:0], 1'b0};
                    r_quo[g]  <= {p_quo[NUM_W-2:0], qbit};
                    r_den[g]  <= p_den;
                    r_side[g] <= p_side;
                end
            end
        end
    endgenerate

    assign o_quo  = r_quo[NUM_W-1];
    assign o_side = r_side[NUM_W-1];

endmodule

@@ hdl/ntcb_log.sv @@
// Two-lane pipelined log2: leading-one normalize, then one squaring per stage.
// Depends on ntcb_pkg for LOG_FRAC and LOG_W.
module ntcb_log
    import ntcb_pkg::*;
#(
    parameter int SIDE_W = 2
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [31:0]       i_x_a,
    input  logic [31:0]       i_x_b,
    input  logic [SIDE_W-1:0] i_side,
    output logic [LOG_W-1:0]  o_log_a,
    output logic [LOG_W-1:0]  o_log_b,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NST = LOG_FRAC + 1;

    logic [31:0]       r_y    [2][NST];
    logic [LOG_W-1:0]  r_res  [2][NST];
    logic [SIDE_W-1:0] r_side [NST];

    genvar l, g;
    generate
        for (l = 0; l < 2; l++) begin : g_lane
            logic [31:0] x;
            logic [4:0]  n0;
            assign x = (l == 0) ? i_x_a : i_x_b;

            // leading-one position
            always_comb begin
                n0 = '0;
                for (int b = 1; b < 32; b++) begin
                    if (x[b]) begin
                        n0 = 5'(b);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_y[l][0]   <= x << (5'd31 - n0);
                    r_res[l][0] <= LOG_W'(n0);
                end
            end

            // one fraction bit per squaring stage
            for (g = 1; g < NST; g++) begin : g_sq
                logic [63:0] sq;
                assign sq = r_y[l][g-1] * r_y[l][g-1];
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_y[l][g]   <= sq[63] ? sq[63:32] : sq[62:31];
                        r_res[l][g] <= {r_res[l][g-1][LOG_W-2:0], sq[63]};
                    end
                end
            end
        end

        for (g = 0; g < NST; g++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[g] <= (g == 0) ? i_side : r_side[(g == 0) ? 0 : g-1];
                end
            end
        end
    endgenerate

    assign o_log_a = r_res[0][NST-1];
    assign o_log_b = r_res[1][NST-1];
    assign o_side  = r_side[NST-1];

endmodule

@@ hdl/ntc_thermistor_beta_temperature.sv @@
// Top level: NTC thermistor temperature by the Beta equation, fully pipelined.
// Depends on ntcb_pkg, ntcb_in_if, ntcb_out_if, ntcb_div and ntcb_log.
//
//   channel   dir  payload                          handshake
//   i_in      in   sense_mv [12:0]                  valid / ready
//   o_out     out  temperature_centi_c, status      valid / ready
//   i_cfg_*   in   idx [2:0], data [19:0]           write enable, no wait
//
// One request enters per cycle while the pipeline advances; each result passes
// through the 39..42 stage bit-per-stage dividers and the 27 stage log2 chain.
// The whole pipeline advances together; it holds while the output is full and
// not taken. Reset clears the valid chain and loads register defaults.
module ntc_thermistor_beta_temperature
    import ntcb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ntcb_in_if.sink               i_in,
    ntcb_out_if.source            o_out
);

    localparam int DIV1_N = 42;
    localparam int DIVT_N = 39;
    localparam int LOG_L  = LOG_FRAC + 1;
    localparam int LAT    = 1 + 1 + DIV1_N + 1 + LOG_L + 3 + DIVT_N + 1 + DIVT_N + 1;

    // configuration registers
    logic [12:0]        r_supply;
    logic [19:0]        r_fixed;
    logic [19:0]        r_nom;
    logic [13:0]        r_beta;
    logic [15:0]        r_t0;
    logic [8:0]         r_margin;
    logic signed [15:0] r_lo;
    logic signed [15:0] r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= RST_SUPPLY_MV;
            r_fixed  <= RST_FIXED_OHMS;
            r_nom    <= RST_NOM_OHMS;
            r_beta   <= RST_BETA;
            r_t0     <= RST_NOM_CK;
            r_margin <= RST_RAIL_MARGIN;
            r_lo     <= RST_TEMP_LOW;
            r_hi     <= RST_TEMP_HIGH;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SUPPLY_MV:    r_supply <= i_cfg_data[12:0];
                CFG_FIXED_OHMS:   r_fixed  <= i_cfg_data[19:0];
                CFG_NOMINAL_OHMS: r_nom    <= i_cfg_data[19:0];
                CFG_BETA_KELVIN:  r_beta   <= i_cfg_data[13:0];
                CFG_NOMINAL_CK:   r_t0     <= i_cfg_data[15:0];
                CFG_RAIL_MARGIN:  r_margin <= i_cfg_data[8:0];
                CFG_TEMP_LOW:     r_lo     <= i_cfg_data[15:0];
                CFG_TEMP_HIGH:    r_hi     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // global advance and valid chain
    logic w_adv;
    logic r_vld [LAT];

    assign w_adv      = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // input register
    logic [12:0] r0_v;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_v <= i_in.sense_mv;
        end
    end

    // rail check and fixed resistor times headroom
    logic [13:0] w1_sum;
    logic [12:0] w1_diff;
    logic [32:0] r1_prod;
    logic [12:0] r1_v;
    t_status     r1_st;

    assign w1_sum  = {1'b0, r0_v} + {5'b0, r_margin};
    assign w1_diff = r_supply - r0_v;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_prod <= r_fixed * w1_diff;
            r1_v    <= r0_v;
            r1_st   <= ((r0_v <= {4'b0, r_margin}) || (w1_sum >= {1'b0, r_supply}))
                       ? ST_RAIL : ST_OK;
        end
    end

    // resistance divide, Q24.8 with round half up
    logic [DIV1_N-1:0] w_d1_num;
    logic [DIV1_N-1:0] w_d1_quo;
    logic [1:0]        w_d1_st;

    assign w_d1_num = {1'b0, r1_prod, 8'd0} + DIV1_N'(r1_v[12:1]);

    ntcb_div #(.NUM_W(DIV1_N), .DEN_W(13), .SIDE_W(2)) u_div_res (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (w_d1_num),
        .i_den  (r1_v),
        .i_side (r1_st),
        .o_quo  (w_d1_quo),
        .o_side (w_d1_st)
    );

    // resistance validity
    logic [31:0] r3_r;
    t_status     r3_st;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_r <= w_d1_quo[31:0];
            if (t_status'(w_d1_st) == ST_OK && (w_d1_quo[31:0] == '0
                    || w_d1_quo[DIV1_N-1:32] != '0 || r_nom == '0)) begin
                r3_st <= ST_RES;
            end else begin
                r3_st <= t_status'(w_d1_st);
            end
        end
    end

    // log2 of resistance and of nominal resistance
    logic [LOG_W-1:0] w_lr;
    logic [LOG_W-1:0] w_l0;
    logic [1:0]       w_lg_st;

    ntcb_log #(.SIDE_W(2)) u_log (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_x_a   (r3_r),
        .i_x_b   ({4'b0, r_nom, 8'd0}),
        .i_side  (r3_st),
        .o_log_a (w_lr),
        .o_log_b (w_l0),
        .o_side  (w_lg_st)
    );

    // log difference magnitude
    logic [31:0] w4_l;
    logic [30:0] r4_mag;
    logic        r4_neg;
    t_status     r4_st;

    assign w4_l = {1'b0, w_lr} - {1'b0, w_l0};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_neg <= w4_l[31];
            r4_mag <= w4_l[31] ? 31'(-w4_l) : w4_l[30:0];
            r4_st  <= t_status'(w_lg_st);
        end
    end

    // scale by ln2
    logic [60:0] r5_prod;
    logic        r5_neg;
    t_status     r5_st;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_prod <= r4_mag * LN2_Q30;
            r5_neg  <= r4_neg;
            r5_st   <= r4_st;
        end
    end

    // round to Q5.24 and form the Beta quotient dividend
    logic [61:0]       w6_sum;
    logic [DIVT_N-1:0] r6_num;
    logic              r6_neg;
    t_status           r6_st;

    assign w6_sum = {1'b0, r5_prod} + 62'h80000000;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_num <= {2'b0, w6_sum[60:32], 8'd0} + DIVT_N'(r_beta[13:1]);
            r6_neg <= r5_neg;
            if (r5_st == ST_OK && (r_t0 == '0 || r_beta == '0)) begin
                r6_st <= ST_TEMP;
            end else begin
                r6_st <= r5_st;
            end
        end
    end

    // ln term over Beta, and inverse nominal temperature, side by side
    logic [DIVT_N-1:0] w_term;
    logic [1:0]        w_d2_st;
    logic [DIVT_N-1:0] w_inv0;
    logic              w_d3_neg;

    ntcb_div #(.NUM_W(DIVT_N), .DEN_W(14), .SIDE_W(2)) u_div_term (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r6_num),
        .i_den  (r_beta),
        .i_side (r6_st),
        .o_quo  (w_term),
        .o_side (w_d2_st)
    );

    ntcb_div #(.NUM_W(DIVT_N), .DEN_W(16), .SIDE_W(1)) u_div_inv0 (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (RECIP_NUM + DIVT_N'(r_t0[15:1])),
        .i_den  (r_t0),
        .i_side (r6_neg),
        .o_quo  (w_inv0),
        .o_side (w_d3_neg)
    );

    // inverse temperature and its range
    logic [40:0] w7_invt;
    logic        w7_bad;
    logic [31:0] r7_invt;
    t_status     r7_st;

    assign w7_invt = w_d3_neg ? ({2'b0, w_inv0} - {2'b0, w_term})
                              : ({2'b0, w_inv0} + {2'b0, w_term});
    assign w7_bad  = w7_invt[40] || (w7_invt == '0) || (w7_invt[39:32] != '0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_invt <= w7_invt[31:0];
            if (t_status'(w_d2_st) == ST_OK && w7_bad) begin
                r7_st <= ST_TEMP;
            end else begin
                r7_st <= t_status'(w_d2_st);
            end
        end
    end

    // temperature in centi-kelvin
    logic [DIVT_N-1:0] w_tck;
    logic [1:0]        w_d4_st;

    ntcb_div #(.NUM_W(DIVT_N), .DEN_W(32), .SIDE_W(2)) u_div_temp (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (RECIP_NUM + DIVT_N'(r7_invt[31:1])),
        .i_den  (r7_invt),
        .i_side (r7_st),
        .o_quo  (w_tck),
        .o_side (w_d4_st)
    );

    // celsius, limit check, output register
    logic signed [40:0] w9_tc;
    logic signed [15:0] r9_temp;
    t_status            r9_st;

    assign w9_tc = $signed({2'b0, w_tck} - CK_OFFSET);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (t_status'(w_d4_st) != ST_OK) begin
                r9_st   <= t_status'(w_d4_st);
                r9_temp <= '0;
            end else if (w9_tc < 41'(r_lo) || w9_tc > 41'(r_hi)) begin
                r9_st   <= ST_TEMP;
                r9_temp <= '0;
            end else begin
                r9_st   <= ST_OK;
                r9_temp <= w9_tc[15:0];
            end
        end
    end

    assign o_out.valid               = r_vld[LAT-1];
    assign o_out.temperature_centi_c = r9_temp;
    assign o_out.status              = r9_st;

endmodule

@@ test/ntc_thermistor_beta_temperature_tb.sv @@
// Self-checking testbench for the NTC thermistor Beta temperature pipeline.
// Depends on ntcb_pkg, ntcb_in_if, ntcb_out_if and ntc_thermistor_beta_temperature.
// Voltage requests are predicted in fixed point and compared to results in order.
module ntc_thermistor_beta_temperature_tb;
    import ntcb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 180;

    typedef struct {
        logic signed [15:0] temp;
        t_status            status;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [2:0]            i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ntcb_in_if  in_ch();
    ntcb_out_if out_ch();

    ntc_thermistor_beta_temperature dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // local copy of the register file
    logic [12:0]        m_supply = RST_SUPPLY_MV;
    logic [19:0]        m_fixed = RST_FIXED_OHMS;
    logic [19:0]        m_nom_ohms = RST_NOM_OHMS;
    logic [13:0]        m_beta = RST_BETA;
    logic [15:0]        m_nom_ck = RST_NOM_CK;
    logic [8:0]         m_margin = RST_RAIL_MARGIN;
    logic signed [15:0] m_low = RST_TEMP_LOW;
    logic signed [15:0] m_high = RST_TEMP_HIGH;

    logic [12:0] pending_mv[$];
    t_reading    expected_readings[$];
    bit          failed = 1'b0;
    bit          taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int unsigned cycle_cnt = 0;
    int          stall_mode = 0;

    always #10 i_clk = ~i_clk;

    // log2 with 26 fraction bits, squaring a normalized mantissa
    function automatic longint unsigned log2_q26(logic [31:0] x);
        int              n;
        longint unsigned y;
        longint unsigned acc;
        n = 31;
        while (n > 0 && x[n] == 1'b0)
            n--;
        y = longint'(x) << (31 - n);
        acc = longint'(n) << 26;
        for (int i = 25; i >= 0; i--) begin
            y = (y * y) >> 31;
            if (y >= 64'h1_0000_0000) begin
                y = y >> 1;
                acc = acc | (64'd1 << i);
            end
        end
        return acc;
    endfunction

    function automatic t_reading predict_reading(logic [12:0] v);
        t_reading        rd;
        longint unsigned r, mag, inv0, invt_u, tck;
        longint          l, ln_q24, term, invt, tc;
        bit              neg;
        rd.temp = '0;
        rd.status = ST_OK;
        if (v <= m_margin || 32'(v) + 32'(m_margin) >= 32'(m_supply)) begin
            rd.status = ST_RAIL;
            return rd;
        end
        r = (64'(m_fixed) * 64'(m_supply - v) * 256 + 64'(v / 2)) / 64'(v);
        if (r == 0 || r > 64'hFFFF_FFFF || m_nom_ohms == 0) begin
            rd.status = ST_RES;
            return rd;
        end
        l = longint'(log2_q26(r[31:0])) - longint'(log2_q26({m_nom_ohms, 8'd0}));
        neg = l < 0;
        mag = 64'(neg ? -l : l) * 64'd744261118;
        mag = (mag + 64'h8000_0000) >> 32;
        ln_q24 = neg ? -longint'(mag) : longint'(mag);
        if (m_nom_ck == 0 || m_beta == 0) begin
            rd.status = ST_TEMP;
            return rd;
        end
        inv0 = ((64'd100 << 32) + 64'(m_nom_ck / 2)) / 64'(m_nom_ck);
        neg = ln_q24 < 0;
        mag = 64'(neg ? -ln_q24 : ln_q24) << 8;
        mag = (mag + 64'(m_beta / 2)) / 64'(m_beta);
        term = neg ? -longint'(mag) : longint'(mag);
        invt = longint'(inv0) + term;
        if (invt <= 0 || invt >= (longint'(1) << 32)) begin
            rd.status = ST_TEMP;
            return rd;
        end
        invt_u = invt;
        tck = ((64'd100 << 32) + invt_u / 2) / invt_u;
        tc = longint'(tck) - 27315;
        if (tc < longint'(m_low) || tc > longint'(m_high)) begin
            rd.status = ST_TEMP;
            return rd;
        end
        rd.temp = tc[15:0];
        return rd;
    endfunction

    // register write, one cycle long, launched on the falling edge
    task automatic write_reg(t_cfg_idx idx, logic [19:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SUPPLY_MV:    m_supply = data[12:0];
            CFG_FIXED_OHMS:   m_fixed = data;
            CFG_NOMINAL_OHMS: m_nom_ohms = data;
            CFG_BETA_KELVIN:  m_beta = data[13:0];
            CFG_NOMINAL_CK:   m_nom_ck = data[15:0];
            CFG_RAIL_MARGIN:  m_margin = data[8:0];
            CFG_TEMP_LOW:     m_low = data[15:0];
            default:          m_high = data[15:0];
        endcase
    endtask

    task automatic load_setting(int supply, int fixed_r, int nom_r, int beta, int nom_ck,
                                int margin, int lo, int hi);
        write_reg(CFG_SUPPLY_MV, 20'(supply));
        write_reg(CFG_FIXED_OHMS, 20'(fixed_r));
        write_reg(CFG_NOMINAL_OHMS, 20'(nom_r));
        write_reg(CFG_BETA_KELVIN, 20'(beta));
        write_reg(CFG_NOMINAL_CK, 20'(nom_ck));
        write_reg(CFG_RAIL_MARGIN, 20'(margin));
        write_reg(CFG_TEMP_LOW, 20'(16'(lo)));
        write_reg(CFG_TEMP_HIGH, 20'(16'(hi)));
    endtask

    // edges of the rail window plus a spread across the span
    task automatic queue_directed();
        pending_mv.push_back(13'd0);
        pending_mv.push_back(13'h1FFF);
        pending_mv.push_back(13'd5000);
        pending_mv.push_back(13'd1);
        pending_mv.push_back(m_margin);
        pending_mv.push_back(m_margin + 13'd1);
        pending_mv.push_back(m_supply - 13'(m_margin));
        pending_mv.push_back(m_supply - 13'(m_margin) - 13'd1);
        pending_mv.push_back(m_supply);
        for (int k = 1; k < 12; k++)
            pending_mv.push_back(13'((32'(m_supply) * k) / 12));
    endtask

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0)
                pending_mv.push_back(13'($urandom_range(8191)));
            else
                pending_mv.push_back(13'($urandom_range(32'(m_supply))));
        end
    endtask

    // let the pipeline empty before touching registers
    task automatic drain();
        wait (pending_mv.size() == 0 && !in_ch.valid && expected_readings.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // request driver, bursts with random gaps
    always @(negedge i_clk) begin
        if (!in_ch.valid || taken) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(40, 1);
                gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            end
            if (gap_left > 0 && burst_left == 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (burst_left > 0 && pending_mv.size() > 0 && i_rst_n) begin
                burst_left--;
                in_ch.sense_mv <= pending_mv.pop_front();
                in_ch.valid <= 1'b1;
            end else begin
                if (burst_left > 0 && pending_mv.size() == 0)
                    burst_left = 0;
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, changes character whenever the counter's low byte is zero
    always @(negedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt[7:0] == 8'd0)
            stall_mode = $urandom_range(3);
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(9) < 7);
            2:       out_ch.ready <= (cycle_cnt % 7 >= 3);
            default: out_ch.ready <= ($urandom_range(9) < 2);
        endcase
    end

    // record accepted requests and their expected readings
    always @(posedge i_clk) begin
        taken <= in_ch.valid && in_ch.ready;
        if (in_ch.valid && in_ch.ready)
            expected_readings.push_back(predict_reading(in_ch.sense_mv));
    end

    // result checker
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result temp %0d status %0d", $time,
                         out_ch.temperature_centi_c, out_ch.status);
                failed = 1'b1;
            end else begin
                want = expected_readings.pop_front();
                if (out_ch.temperature_centi_c !== want.temp) begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             want.temp, out_ch.temperature_centi_c);
                    failed = 1'b1;
                end
                if (out_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, out_ch.status);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sense_mv = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults after reset
        queue_directed();
        queue_random(100);
        drain();

        // upper extremes
        load_setting(5000, 1000000, 1000000, 10000, 40000, 500, -5000, 20000);
        queue_directed();
        queue_random(80);
        drain();

        // lower extremes, huge resistance ratio
        load_setting(1000, 100, 1000000, 1000, 20000, 0, -5000, 20000);
        queue_directed();
        queue_random(60);
        drain();

        // small nominal resistance, big fixed resistor
        load_setting(5000, 1000000, 100, 1000, 40000, 0, -5000, 20000);
        queue_directed();
        queue_random(60);
        drain();

        // inverted limits: every reading past the rail and resistance checks is out of range
        load_setting(3300, 10000, 10000, 3470, 29815, 10, 20000, -5000);
        queue_random(40);
        drain();

        // degenerate beta, nominal temperature and nominal resistance
        load_setting(3300, 10000, 10000, 0, 29815, 10, -5000, 20000);
        queue_random(20);
        drain();
        write_reg(CFG_BETA_KELVIN, 20'd3470);
        write_reg(CFG_NOMINAL_CK, 20'd0);
        queue_random(20);
        drain();
        write_reg(CFG_NOMINAL_CK, 20'd29815);
        write_reg(CFG_NOMINAL_OHMS, 20'd0);
        queue_random(20);
        drain();

        // random settings, mostly wide limits
        for (int ph = 0; ph < 6; ph++) begin
            load_setting($urandom_range(5000, 1000), $urandom_range(1000000, 100),
                         $urandom_range(1000000, 100), $urandom_range(10000, 1000),
                         $urandom_range(40000, 20000), $urandom_range(500),
                         ($urandom_range(1)) ? -5000 : $urandom_range(3000) - 5000,
                         ($urandom_range(1)) ? 20000 : $urandom_range(20000, 2000));
            queue_random(70);
            drain();
        end

        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
